### rtl/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator checker.
// Used by the checker file only; needs signals clk and rst in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("buddy_page_allocator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BPA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("buddy_page_allocator: next-cycle check failed");

`endif

### rtl/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bpa_pkg;

  localparam int PAGE_COUNT    = 4096;
  localparam int ORDERS        = 10;
  localparam int TOP_ORDER     = ORDERS - 1;
  localparam int PFN_W         = $clog2(PAGE_COUNT);
  localparam int ORD_W         = 4;
  localparam int CNT_W         = PFN_W + 1;
  localparam int CFG_W         = 4;
  localparam int TOP_BITS      = PAGE_COUNT >> TOP_ORDER;
  localparam int WORD_W        = 64;
  localparam int WBIT_W        = $clog2(WORD_W);
  localparam int TOP_BLOCKS_RST = 8;
  localparam logic [ORD_W-1:0] NOT_ALLOC = ORD_W'(15);

  // Number of free-map words that hold the bits of order k.
  function automatic int words_of(int k);
    return ((PAGE_COUNT >> k) + WORD_W - 1) / WORD_W;
  endfunction

  // First free-map word of order k; words are laid out by rising order.
  function automatic int base_of(int k);
    int base;
    base = 0;
    for (int j = 0; j < ORDERS; j++) begin
      if (j < k) base = base + words_of(j);
    end
    return base;
  endfunction

  localparam int NUM_WORDS = base_of(ORDERS);
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int TOP_WORD  = base_of(TOP_ORDER);

  // Order whose range of words holds word w.
  function automatic int order_of(int w);
    int k;
    k = 0;
    for (int j = 0; j < ORDERS; j++) begin
      if (w >= base_of(j)) k = j;
    end
    return k;
  endfunction

  // Top-order free bits for n managed blocks, saturating at the pool size.
  function automatic logic [TOP_BITS-1:0] top_mask(logic [CFG_W-1:0] n);
    logic [TOP_BITS-1:0] m;
    for (int i = 0; i < TOP_BITS; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_REBUILD,
    OP_SEARCH,
    OP_RD_FOUND,
    OP_PICK,
    OP_SPLIT_RD,
    OP_SET_BIT,
    OP_ALLOC_END,
    OP_BO_RD,
    OP_FREE_START,
    OP_BUD_RD,
    OP_MERGE,
    OP_FIN_RD,
    OP_FREE_END,
    OP_REPORT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_RCLR,
    S_IDLE,
    S_DECODE,
    S_A_CHK,
    S_A_PICK,
    S_A_SPLIT,
    S_A_SPLIT_WR,
    S_F_CHK,
    S_F_LOOP,
    S_F_BUD,
    S_F_FIN,
    S_ICLR,
    S_IREP
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic too_large;
    logic found;
    logic bit_set;
    logic bo_invalid;
    logic ord_top;
    logic split_more;
    logic clr_last;
  } dp_stat_t;

endpackage

### rtl/bpa_ctrl.sv
// Controller of the buddy page allocator: sequences allocate, free and
// reinitialize over the datapath. Depends on bpa_pkg.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  cmd
);

  bpa_pkg::state_t state, state_next;

  // State register; reset starts the clearing pass of the order table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != bpa_pkg::S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next     = state;
    cmd.op         = bpa_pkg::OP_NOP;
    cmd.res_status = bpa_pkg::ST_OK;
    unique case (state)
      bpa_pkg::S_RCLR: begin
        cmd.op = bpa_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = bpa_pkg::OP_LOAD;
          state_next = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        unique case (stat.cmd)
          bpa_pkg::CMD_ALLOC: begin
            if (stat.too_large) begin
              cmd.op         = bpa_pkg::OP_REPORT;
              cmd.res_status = bpa_pkg::ST_TOO_LARGE;
              state_next     = bpa_pkg::S_IDLE;
            end else begin
              cmd.op     = bpa_pkg::OP_SEARCH;
              state_next = bpa_pkg::S_A_CHK;
            end
          end
          bpa_pkg::CMD_FREE: begin
            cmd.op     = bpa_pkg::OP_BO_RD;
            state_next = bpa_pkg::S_F_CHK;
          end
          bpa_pkg::CMD_INIT: begin
            cmd.op     = bpa_pkg::OP_REBUILD;
            state_next = bpa_pkg::S_ICLR;
          end
          default: begin
            cmd.op     = bpa_pkg::OP_REPORT;
            state_next = bpa_pkg::S_IDLE;
          end
        endcase
      end
      bpa_pkg::S_A_CHK: begin
        if (stat.found) begin
          cmd.op     = bpa_pkg::OP_RD_FOUND;
          state_next = bpa_pkg::S_A_PICK;
        end else begin
          cmd.op         = bpa_pkg::OP_REPORT;
          cmd.res_status = bpa_pkg::ST_NO_FREE;
          state_next     = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_A_PICK: begin
        cmd.op     = bpa_pkg::OP_PICK;
        state_next = bpa_pkg::S_A_SPLIT;
      end
      bpa_pkg::S_A_SPLIT: begin
        if (stat.split_more) begin
          cmd.op     = bpa_pkg::OP_SPLIT_RD;
          state_next = bpa_pkg::S_A_SPLIT_WR;
        end else begin
          cmd.op     = bpa_pkg::OP_ALLOC_END;
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_A_SPLIT_WR: begin
        cmd.op     = bpa_pkg::OP_SET_BIT;
        state_next = bpa_pkg::S_A_SPLIT;
      end
      bpa_pkg::S_F_CHK: begin
        if (stat.bo_invalid) begin
          cmd.op         = bpa_pkg::OP_REPORT;
          cmd.res_status = bpa_pkg::ST_BAD_FREE;
          state_next     = bpa_pkg::S_IDLE;
        end else begin
          cmd.op     = bpa_pkg::OP_FREE_START;
          state_next = bpa_pkg::S_F_LOOP;
        end
      end
      bpa_pkg::S_F_LOOP: begin
        if (stat.ord_top) begin
          cmd.op     = bpa_pkg::OP_FIN_RD;
          state_next = bpa_pkg::S_F_FIN;
        end else begin
          cmd.op     = bpa_pkg::OP_BUD_RD;
          state_next = bpa_pkg::S_F_BUD;
        end
      end
      bpa_pkg::S_F_BUD: begin
        if (stat.bit_set) begin
          cmd.op     = bpa_pkg::OP_MERGE;
          state_next = bpa_pkg::S_F_LOOP;
        end else begin
          cmd.op     = bpa_pkg::OP_FIN_RD;
          state_next = bpa_pkg::S_F_FIN;
        end
      end
      bpa_pkg::S_F_FIN: begin
        cmd.op     = bpa_pkg::OP_FREE_END;
        state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_ICLR: begin
        cmd.op = bpa_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = bpa_pkg::S_IREP;
      end
      bpa_pkg::S_IREP: begin
        cmd.op     = bpa_pkg::OP_REPORT;
        state_next = bpa_pkg::S_IDLE;
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bpa_dp.sv
// Datapath of the buddy page allocator: free-map word memory with nonzero
// flags, block order table, search and bit logic. Depends on bpa_pkg.
module bpa_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  bpa_pkg::dp_cmd_t            cmd,
  output bpa_pkg::dp_stat_t           stat,
  input  logic [1:0]                  command,
  input  logic [bpa_pkg::CNT_W-1:0]   page_count,
  input  logic [bpa_pkg::PFN_W-1:0]   block_pfn,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [bpa_pkg::PFN_W-1:0]   result_pfn,
  output logic [bpa_pkg::ORD_W-1:0]   result_order
);

  // Memories.
  logic [bpa_pkg::WORD_W-1:0]   map_mem [bpa_pkg::NUM_WORDS];
  logic [bpa_pkg::ORD_W-1:0]    bo_mem  [bpa_pkg::PAGE_COUNT];

  // Nonzero flag per free-map word; a clear flag means the word reads as zero.
  logic [bpa_pkg::NUM_WORDS-1:0] flags;
  logic [bpa_pkg::TOP_BITS-1:0]  topword;
  logic [bpa_pkg::CFG_W-1:0]     top_blocks;

  bpa_pkg::cmd_t                 cmd_q;
  logic [bpa_pkg::ORD_W-1:0]     want;
  logic [bpa_pkg::ORD_W-1:0]     ord;
  logic [bpa_pkg::PFN_W-1:0]     pfn;
  logic [bpa_pkg::WADDR_W-1:0]   srch_w;
  logic                          found_q;
  logic [bpa_pkg::WADDR_W-1:0]   waddr;
  logic [bpa_pkg::WBIT_W-1:0]    wbit;
  logic [bpa_pkg::WORD_W-1:0]    mem_q;
  logic                          rd_top;
  logic                          rd_flag;
  logic [bpa_pkg::ORD_W-1:0]     bo_q;
  logic [bpa_pkg::PFN_W-1:0]     clr_cnt;

  logic [bpa_pkg::WORD_W-1:0]    rword;
  logic [bpa_pkg::ORD_W-1:0]     want_c;
  logic                          found_c;
  logic [bpa_pkg::WADDR_W-1:0]   found_w;
  logic [bpa_pkg::WBIT_W-1:0]    first_b;
  logic                          rd_en;
  logic [bpa_pkg::WADDR_W-1:0]   rd_addr;
  logic [bpa_pkg::WBIT_W-1:0]    rd_bit;
  logic                          wr_en;
  logic [bpa_pkg::WORD_W-1:0]    wr_data;
  logic [bpa_pkg::PFN_W-1:0]     pick_pfn;
  logic [bpa_pkg::ORD_W-1:0]     split_ord;

  // Current word: top order lives in a register, other words behind flags.
  always_comb begin
    rword = '0;
    if (rd_top) begin
      rword[bpa_pkg::TOP_BITS-1:0] = topword;
    end else if (rd_flag) begin
      rword = mem_q;
    end
  end

  // Rounded order of the requested page count (ceiling log2, zero as one).
  always_comb begin
    logic [bpa_pkg::CNT_W-1:0] cm1;
    cm1    = (page_count == '0) ? '0 : page_count - bpa_pkg::CNT_W'(1);
    want_c = '0;
    for (int i = 0; i < bpa_pkg::CNT_W; i++) begin
      if (cm1[i]) want_c = bpa_pkg::ORD_W'(i + 1);
    end
  end

  // Lowest nonzero word at or above the wanted order's first word.
  always_comb begin
    logic fv;
    int   lo;
    lo      = bpa_pkg::base_of(int'(want));
    found_c = 1'b0;
    found_w = '0;
    for (int i = bpa_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      fv = (i == bpa_pkg::TOP_WORD) ? (|topword) : flags[i];
      if (fv && (i >= lo)) begin
        found_c = 1'b1;
        found_w = bpa_pkg::WADDR_W'(i);
      end
    end
  end

  // Lowest set bit of the current word.
  always_comb begin
    first_b = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (rword[i]) first_b = bpa_pkg::WBIT_W'(i);
    end
  end

  // Page of the picked block from word, bit and order.
  always_comb begin
    int idx;
    idx      = ((int'(waddr) - bpa_pkg::base_of(int'(ord))) << bpa_pkg::WBIT_W)
               | int'(first_b);
    pick_pfn = bpa_pkg::PFN_W'(idx << ord);
  end

  assign split_ord = ord - bpa_pkg::ORD_W'(1);

  // Free-map read address and bit for the commanded block.
  always_comb begin
    int k;
    int idx;
    rd_en = 1'b1;
    k     = int'(ord);
    idx   = int'(pfn) >> ord;
    unique case (cmd.op)
      bpa_pkg::OP_SPLIT_RD: begin
        k   = int'(split_ord);
        idx = (int'(pfn) + (1 << split_ord)) >> split_ord;
      end
      bpa_pkg::OP_BUD_RD: begin
        idx = (int'(pfn) ^ (1 << ord)) >> ord;
      end
      bpa_pkg::OP_FIN_RD: begin
      end
      bpa_pkg::OP_RD_FOUND: begin
        idx = 0;
      end
      default: rd_en = 1'b0;
    endcase
    rd_addr = bpa_pkg::WADDR_W'(bpa_pkg::base_of(k) + (idx >> bpa_pkg::WBIT_W));
    rd_bit  = idx[bpa_pkg::WBIT_W-1:0];
    if (cmd.op == bpa_pkg::OP_RD_FOUND) begin
      rd_addr = srch_w;
    end
  end

  // Free-map write-back of the current word.
  always_comb begin
    wr_en   = 1'b1;
    wr_data = rword;
    unique case (cmd.op)
      bpa_pkg::OP_PICK:     wr_data = rword & ~(bpa_pkg::WORD_W'(1) << first_b);
      bpa_pkg::OP_MERGE:    wr_data = rword & ~(bpa_pkg::WORD_W'(1) << wbit);
      bpa_pkg::OP_SET_BIT,
      bpa_pkg::OP_FREE_END: wr_data = rword | (bpa_pkg::WORD_W'(1) << wbit);
      default:              wr_en   = 1'b0;
    endcase
  end

  // Free-map word memory.
  always_ff @(posedge clk) begin
    if (wr_en && (waddr != bpa_pkg::WADDR_W'(bpa_pkg::TOP_WORD))) begin
      map_mem[waddr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= map_mem[rd_addr];
    end
  end

  // Flags, top-order word and the configured block count.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      topword    <= bpa_pkg::top_mask(bpa_pkg::CFG_W'(bpa_pkg::TOP_BLOCKS_RST));
      top_blocks <= bpa_pkg::CFG_W'(bpa_pkg::TOP_BLOCKS_RST);
    end else begin
      if (cfg_we) top_blocks <= cfg_wdata;
      if (cmd.op == bpa_pkg::OP_REBUILD) begin
        flags   <= '0;
        topword <= bpa_pkg::top_mask(top_blocks);
      end else if (wr_en) begin
        if (waddr == bpa_pkg::WADDR_W'(bpa_pkg::TOP_WORD)) begin
          topword <= wr_data[bpa_pkg::TOP_BITS-1:0];
        end else begin
          flags[waddr] <= |wr_data;
        end
      end
    end
  end

  // Block order table: clearing pass, allocate record and free release.
  always_ff @(posedge clk) begin
    priority case (cmd.op)
      bpa_pkg::OP_CLEAR:      bo_mem[clr_cnt] <= bpa_pkg::NOT_ALLOC;
      bpa_pkg::OP_ALLOC_END:  bo_mem[pfn]     <= want;
      bpa_pkg::OP_FREE_START: bo_mem[pfn]     <= bpa_pkg::NOT_ALLOC;
      default: ;
    endcase
    if (cmd.op == bpa_pkg::OP_BO_RD) begin
      bo_q <= bo_mem[pfn];
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst || (cmd.op == bpa_pkg::OP_REBUILD)) begin
      clr_cnt <= '0;
    end else if (cmd.op == bpa_pkg::OP_CLEAR) begin
      clr_cnt <= clr_cnt + bpa_pkg::PFN_W'(1);
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      waddr   <= rd_addr;
      wbit    <= rd_bit;
      rd_top  <= (rd_addr == bpa_pkg::WADDR_W'(bpa_pkg::TOP_WORD));
      rd_flag <= flags[rd_addr];
    end
    unique case (cmd.op)
      bpa_pkg::OP_LOAD: begin
        cmd_q <= bpa_pkg::cmd_t'(command);
        pfn   <= block_pfn;
        want  <= want_c;
      end
      bpa_pkg::OP_SEARCH: begin
        found_q <= found_c;
        srch_w  <= found_w;
        ord     <= bpa_pkg::ORD_W'(bpa_pkg::order_of(int'(found_w)));
      end
      bpa_pkg::OP_PICK:       pfn <= pick_pfn;
      bpa_pkg::OP_SPLIT_RD:   ord <= split_ord;
      bpa_pkg::OP_FREE_START: ord <= bo_q;
      bpa_pkg::OP_MERGE: begin
        pfn <= pfn & ~(bpa_pkg::PFN_W'(1) << ord);
        ord <= ord + bpa_pkg::ORD_W'(1);
      end
      default: ;
    endcase
  end

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == bpa_pkg::OP_REPORT) || (cmd.op == bpa_pkg::OP_ALLOC_END) ||
              (cmd.op == bpa_pkg::OP_FREE_END);
    end
    unique case (cmd.op)
      bpa_pkg::OP_REPORT: begin
        status       <= cmd.res_status;
        result_pfn   <= '0;
        result_order <= '0;
      end
      bpa_pkg::OP_ALLOC_END: begin
        status       <= bpa_pkg::ST_OK;
        result_pfn   <= pfn;
        result_order <= want;
      end
      bpa_pkg::OP_FREE_END: begin
        status       <= bpa_pkg::ST_OK;
        result_pfn   <= pfn;
        result_order <= ord;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  assign stat.cmd        = cmd_q;
  assign stat.too_large  = (want > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
  assign stat.found      = found_q;
  assign stat.bit_set    = rword[wbit];
  assign stat.bo_invalid = (bo_q >= bpa_pkg::ORD_W'(bpa_pkg::ORDERS));
  assign stat.ord_top    = (ord == bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
  assign stat.split_more = (ord > want);
  assign stat.clr_last   = (clr_cnt == bpa_pkg::PFN_W'(bpa_pkg::PAGE_COUNT - 1));

endmodule

### rtl/buddy_page_allocator.sv
// Buddy page allocator top level. Allocate time grows with the number of splits and free time
// with the number of merges; errors and unknown commands end without them. Reinitialize is
// mostly a clearing pass of the order table; reset starts the same pass with busy high. One
// item at a time, the next one accepted in the result cycle; the strobe is one cycle wide and
// the receiver cannot stall. Needs bpa_pkg.
module buddy_page_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [bpa_pkg::CNT_W-1:0]   page_count,
  input  logic [bpa_pkg::PFN_W-1:0]   block_pfn,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [bpa_pkg::PFN_W-1:0]   result_pfn,
  output logic [bpa_pkg::ORD_W-1:0]   result_order
);

  bpa_pkg::dp_cmd_t  dp_cmd;
  bpa_pkg::dp_stat_t dp_stat;

  // Sequencer.
  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  // Storage and arithmetic.
  bpa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .command      (command),
    .page_count   (page_count),
    .block_pfn    (block_pfn),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .result_pfn   (result_pfn),
    .result_order (result_order)
  );

endmodule

### rtl/bpa_checker.sv
// Port-level checks of the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator_macros.svh.
`include "buddy_page_allocator_macros.svh"

module bpa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [1:0]                status,
  input logic [bpa_pkg::PFN_W-1:0] result_pfn,
  input logic [bpa_pkg::ORD_W-1:0] result_order
);

  // An accepted item keeps the block busy in the next cycle.
  `BPA_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // Results are never back to back, and come while the block is idle.
  `BPA_ASSERT_NXT(a_done_single, done, !done)
  `BPA_ASSERT_IMP(a_done_idle, done, !busy)

  // Error results carry zero page and order.
  `BPA_ASSERT_IMP(a_err_zero, done && (status != bpa_pkg::ST_OK),
                  (result_pfn == '0) && (result_order == '0))

  // A successful result names a valid order.
  `BPA_ASSERT_IMP(a_ok_order, done && (status == bpa_pkg::ST_OK),
                  result_order <= bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER))

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
